>>> hdl/ise_pkg.sv
// Shared types and constants for the integer stack engine.
package ise_pkg;

  // Request codes carried in req_type.
  typedef enum logic [2:0] {
    REQ_PUSH = 3'd0,
    REQ_DUMP = 3'd1,
    REQ_PEEK = 3'd2,
    REQ_POP  = 3'd3,
    REQ_SWAP = 3'd4
  } req_e_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_PEEK_EMPTY = 3'd1,
    ST_POP_EMPTY  = 3'd2,
    ST_SWAP_SHORT = 3'd3,
    ST_PUSH_FULL  = 3'd4
  } status_e_t;

  // Fewest entries that a swap needs.
  localparam int unsigned SWAP_MIN_ENTRIES = 2;

  // Input beat.
  typedef struct packed {
    logic        [2:0]  req_type;
    logic signed [31:0] push_value;
  } in_t;

  // Result beat.
  typedef struct packed {
    logic signed [31:0] read_value;
    logic        [2:0]  status;
    logic               last_of_run;
  } out_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_RESP,
    S_PEEK,
    S_SWAP_A,
    S_SWAP_B,
    S_SWAP_C,
    S_DUMP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       wr_en;       // write the entry store
    logic       wr_at_cm1;   // write address count-1
    logic       wr_at_cm2;   // write address count-2 (else count)
    logic       wr_data_rd;  // write data from read register
    logic       wr_data_tmp; // write data from swap holding register (else push value)
    logic       rd_en;       // read the entry store
    logic       rd_at_cm2;   // read address count-2
    logic       rd_at_ptr;   // read address dump pointer - 1 (else count-1)
    logic       cnt_inc;
    logic       cnt_dec;
    logic       ptr_load;    // dump pointer takes count-1
    logic       ptr_dec;
    logic       tmp_load;    // hold the read data for a swap
    logic       emit;        // load the result register
    logic       emit_rd;     // result value from read register (else zero)
    logic [2:0] emit_status;
    logic       emit_last;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic count_short;  // fewer entries than a swap needs
    logic full;
    logic ptr_zero;
    logic slot_free;    // result register can take a beat
  } dp_sts_t;

endpackage

>>> hdl/ise_ctrl.sv
// Controller state machine of the integer stack engine.
module ise_ctrl
  import ise_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     [2:0] in_req,
  output logic     in_ready,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  state_t     state_r, state_nxt;
  logic [2:0] resp_st_r, resp_st_nxt;

  // State and pending response status registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      resp_st_r <= ST_OK;
    end else begin
      state_r   <= state_nxt;
      resp_st_r <= resp_st_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt   = state_r;
    resp_st_nxt = resp_st_r;
    in_ready    = 1'b0;
    cmd         = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (req_e_t'(in_req))
            REQ_PUSH: begin
              if (sts.full) begin
                resp_st_nxt = ST_PUSH_FULL;
              end else begin
                resp_st_nxt = ST_OK;
                cmd.wr_en   = 1'b1;
                cmd.cnt_inc = 1'b1;
              end
              state_nxt = S_RESP;
            end
            REQ_DUMP: begin
              if (!sts.count_zero) begin
                cmd.rd_en    = 1'b1;
                cmd.ptr_load = 1'b1;
                state_nxt    = S_DUMP;
              end
            end
            REQ_PEEK: begin
              if (sts.count_zero) begin
                resp_st_nxt = ST_PEEK_EMPTY;
                state_nxt   = S_RESP;
              end else begin
                cmd.rd_en = 1'b1;
                state_nxt = S_PEEK;
              end
            end
            REQ_POP: begin
              if (sts.count_zero) begin
                resp_st_nxt = ST_POP_EMPTY;
              end else begin
                resp_st_nxt = ST_OK;
                cmd.cnt_dec = 1'b1;
              end
              state_nxt = S_RESP;
            end
            REQ_SWAP: begin
              if (sts.count_short) begin
                resp_st_nxt = ST_SWAP_SHORT;
                state_nxt   = S_RESP;
              end else begin
                resp_st_nxt = ST_OK;
                cmd.rd_en   = 1'b1;
                state_nxt   = S_SWAP_A;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_RESP: begin
        // Single result with zero value and the pending status.
        if (sts.slot_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = resp_st_r;
          cmd.emit_last   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_PEEK: begin
        if (sts.slot_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_rd     = 1'b1;
          cmd.emit_status = ST_OK;
          cmd.emit_last   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_SWAP_A: begin
        // Top entry is in the read register; fetch the one below it.
        cmd.tmp_load  = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_at_cm2 = 1'b1;
        state_nxt     = S_SWAP_B;
      end
      S_SWAP_B: begin
        // Second entry moves to the top slot.
        cmd.wr_en      = 1'b1;
        cmd.wr_at_cm1  = 1'b1;
        cmd.wr_data_rd = 1'b1;
        state_nxt      = S_SWAP_C;
      end
      S_SWAP_C: begin
        // Old top moves to the second slot.
        cmd.wr_en       = 1'b1;
        cmd.wr_at_cm2   = 1'b1;
        cmd.wr_data_tmp = 1'b1;
        state_nxt       = S_RESP;
      end
      S_DUMP: begin
        // One entry per beat, top to bottom.
        if (sts.slot_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_rd     = 1'b1;
          cmd.emit_status = ST_OK;
          cmd.emit_last   = sts.ptr_zero;
          if (sts.ptr_zero) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.rd_en     = 1'b1;
            cmd.rd_at_ptr = 1'b1;
            cmd.ptr_dec   = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/ise_dp.sv
// Datapath of the integer stack engine: entry store, count, pointers and result register.
module ise_dp
  import ise_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic signed [31:0] push_value,
  input  ctl_cmd_t cmd,
  output dp_sts_t  sts,
  output logic     out_valid,
  input  logic     out_ready,
  output out_t     out_data
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);

  logic [31:0]   mem [DEPTH];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [31:0]   rd_data_r;
  logic [31:0]   tmp_r;
  logic          out_valid_r;
  out_t          out_data_r;

  logic [CW-1:0] cnt_m1, cnt_m2;
  logic [AW-1:0] ptr_m1;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [31:0]   wr_data;

  assign cnt_m1 = cnt_r - CW'(1);
  assign cnt_m2 = cnt_r - CW'(2);
  assign ptr_m1 = ptr_r - AW'(1);

  // Address and write data selection.
  always_comb begin
    if (cmd.wr_at_cm1) begin
      wr_addr = cnt_m1[AW-1:0];
    end else if (cmd.wr_at_cm2) begin
      wr_addr = cnt_m2[AW-1:0];
    end else begin
      wr_addr = cnt_r[AW-1:0];
    end
    if (cmd.wr_data_rd) begin
      wr_data = rd_data_r;
    end else if (cmd.wr_data_tmp) begin
      wr_data = tmp_r;
    end else begin
      wr_data = push_value;
    end
    if (cmd.rd_at_cm2) begin
      rd_addr = cnt_m2[AW-1:0];
    end else if (cmd.rd_at_ptr) begin
      rd_addr = ptr_m1;
    end else begin
      rd_addr = cnt_m1[AW-1:0];
    end
  end

  // Entry store with registered read.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Swap holding register.
  always_ff @(posedge clk) begin
    if (cmd.tmp_load) begin
      tmp_r <= rd_data_r;
    end
  end

  // Entry count and dump pointer.
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_m1;
    end
    ptr_nxt = ptr_r;
    if (cmd.ptr_load) begin
      ptr_nxt = cnt_m1[AW-1:0];
    end else if (cmd.ptr_dec) begin
      ptr_nxt = ptr_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ptr_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      ptr_r <= ptr_nxt;
    end
  end

  // Result register: holds a beat until the consumer takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.read_value  <= cmd.emit_rd ? rd_data_r : 32'sd0;
      out_data_r.status      <= cmd.emit_status;
      out_data_r.last_of_run <= cmd.emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status toward the controller.
  assign sts.count_zero  = (cnt_r == '0);
  assign sts.count_short = (cnt_r < CW'(SWAP_MIN_ENTRIES));
  assign sts.full        = (cnt_r == CW'(DEPTH));
  assign sts.ptr_zero    = (ptr_r == '0);
  assign sts.slot_free   = !out_valid_r || out_ready;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> (!sts.full && cmd.wr_en))
    else $error("push into a full stack");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |=> (cnt_r == $past(cnt_r) - CW'(1)))
    else $error("pop did not lower the count by one");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.slot_free)
    else $error("result overwritten before it was taken");
`endif

endmodule

>>> hdl/integer_stack_engine.sv
// Top level of the integer stack engine: controller and datapath.
//
// A bounded LIFO of signed 32-bit entries with push, pop, peek, swap and dump.
// One request is worked on at a time; in_ready is high only while the block
// waits for a request. Push, pop and every error case go through S_RESP, peek
// through S_PEEK, swap through S_SWAP_A, S_SWAP_B, S_SWAP_C and S_RESP; a dump
// gives one result beat per cycle, top to bottom, while the consumer takes them.
// A dump of an empty stack and an unused request code give no result. These
// steps come from the single write port and the registered read of the entry
// store. A stalled result beat holds the block until the consumer takes it; a
// new request can be accepted while the last result of the previous one waits.
module integer_stack_engine
  import ise_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  ise_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_req   (in_data.req_type),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ise_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_value (in_data.push_value),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

>>> dv/integer_stack_engine_tb.sv
// Self-checking testbench for the integer stack engine: LIFO predictor and result scoreboard.
module integer_stack_engine_tb
  import ise_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STACK_DEPTH  = 32;
  localparam int unsigned QUIET_CYCLES = STACK_DEPTH + 8;
  localparam int unsigned REPORT_LIMIT = 10;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // Shadow copy of the stack and the results it predicts.
  logic signed [31:0] shadow_entries [STACK_DEPTH];
  int unsigned        shadow_count = 0;
  out_t               results_due [$];

  // Stall control for each side and run statistics.
  bit          in_stall_on  = 1'b0;
  bit          out_stall_on = 1'b0;
  int unsigned ready_hold   = 0;
  int unsigned fail_count   = 0;
  int unsigned requests_taken = 0;
  int unsigned beats_checked  = 0;
  int unsigned error_beats    = 0;
  int unsigned full_dumps     = 0;

  integer_stack_engine #(
    .DEPTH(STACK_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Idle cycles before the next beat on one side; stretches with stalls off run back to back.
  function automatic int unsigned draw_gap(input bit stall_on);
    if (!stall_on || $urandom_range(0, 3) == 0) begin
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
  endtask

  // Apply one accepted request to the shadow stack and queue the results it causes.
  task automatic predict_stack_op(input in_t req);
    out_t               beat;
    logic signed [31:0] held;
    int unsigned        k;
    beat             = '0;
    beat.last_of_run = 1'b1;
    requests_taken++;
    case (req.req_type)
      REQ_PUSH: begin
        if (shadow_count == STACK_DEPTH) begin
          beat.status = ST_PUSH_FULL;
        end else begin
          shadow_entries[shadow_count] = req.push_value;
          shadow_count++;
        end
        results_due.push_back(beat);
      end
      REQ_DUMP: begin
        if (shadow_count == STACK_DEPTH) begin
          full_dumps++;
        end
        // Top first; the bottom entry closes the run.
        for (k = 0; k < shadow_count; k++) begin
          beat.read_value  = shadow_entries[shadow_count - 1 - k];
          beat.last_of_run = (k + 1 == shadow_count);
          results_due.push_back(beat);
        end
      end
      REQ_PEEK: begin
        if (shadow_count == 0) begin
          beat.status = ST_PEEK_EMPTY;
        end else begin
          beat.read_value = shadow_entries[shadow_count - 1];
        end
        results_due.push_back(beat);
      end
      REQ_POP: begin
        if (shadow_count == 0) begin
          beat.status = ST_POP_EMPTY;
        end else begin
          shadow_count--;
        end
        results_due.push_back(beat);
      end
      REQ_SWAP: begin
        if (shadow_count < SWAP_MIN_ENTRIES) begin
          beat.status = ST_SWAP_SHORT;
        end else begin
          held                             = shadow_entries[shadow_count - 1];
          shadow_entries[shadow_count - 1] = shadow_entries[shadow_count - 2];
          shadow_entries[shadow_count - 2] = held;
        end
        results_due.push_back(beat);
      end
      default: begin
        // Unused request codes change nothing and give no result.
      end
    endcase
  endtask

  // Compare one result beat with the oldest prediction.
  task automatic check_result_beat(input out_t got);
    out_t want;
    if (results_due.size() == 0) begin
      note_failure($sformatf("result beat with nothing expected: value %0d status %0d last %0b",
                             got.read_value, got.status, got.last_of_run));
      return;
    end
    want = results_due.pop_front();
    beats_checked++;
    if (want.status != ST_OK) begin
      error_beats++;
    end
    if (got.read_value !== want.read_value || got.status !== want.status ||
        got.last_of_run !== want.last_of_run) begin
      note_failure($sformatf("beat %0d: expected value %0d status %0d last %0b, got %0d %0d %0b",
                             beats_checked, want.read_value, want.status, want.last_of_run,
                             got.read_value, got.status, got.last_of_run));
    end
  endtask

  // One process sees both handshakes, so a prediction always lands before its result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_stack_op(in_data);
      end
      if (out_valid && out_ready) begin
        check_result_beat(out_data);
      end
    end
  end

  // Result side: after each taken beat, hold ready low for a drawn number of cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_hold = 0;
    end else if (out_valid && out_ready) begin
      ready_hold = draw_gap(out_stall_on);
      out_ready <= (ready_hold == 0);
    end else if (ready_hold > 0) begin
      ready_hold--;
      out_ready <= (ready_hold == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Send one request beat; valid stays up after acceptance until the next call or a drain.
  task automatic send_request(input logic [2:0] code, input logic signed [31:0] value);
    int unsigned gap;
    in_t         beat;
    beat.req_type   = code;
    beat.push_value = value;
    gap             = draw_gap(in_stall_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and wait until every predicted result has arrived, plus a quiet margin.
  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Every operation on an empty stack, swap and pop on a one-entry stack, and the unused codes.
  task automatic test_empty_stack_errors();
    in_stall_on  = 1'b0;
    out_stall_on = 1'b0;
    send_request(REQ_DUMP, 32'sd0);
    send_request(REQ_PEEK, 32'sd0);
    send_request(REQ_POP, 32'sd0);
    send_request(REQ_SWAP, 32'sd0);
    send_request(3'd5, -32'sd1);
    send_request(3'd6, -32'sd1);
    send_request(3'd7, -32'sd1);
    send_request(REQ_PUSH, 32'sd0);
    send_request(REQ_SWAP, 32'sd0);
    send_request(REQ_POP, 32'sd0);
    wait_for_quiet();
  endtask

  // Extreme values through push, peek, swap and dump.
  task automatic test_value_extremes();
    in_stall_on  = 1'b1;
    out_stall_on = 1'b1;
    send_request(REQ_PUSH, 32'sh8000_0000);
    send_request(REQ_PUSH, 32'sh7FFF_FFFF);
    send_request(REQ_PUSH, -32'sd1);
    send_request(REQ_PUSH, 32'sh5555_AAAA);
    send_request(REQ_PEEK, 32'sd0);
    send_request(REQ_SWAP, 32'sd0);
    send_request(REQ_PEEK, 32'sd0);
    send_request(REQ_DUMP, 32'sd0);
    repeat (4) send_request(REQ_POP, 32'sd0);
    send_request(REQ_PEEK, 32'sd0);
    wait_for_quiet();
  endtask

  // Fill to the top, overflow, dump the full stack, then empty it again.
  task automatic test_full_stack();
    int unsigned k;
    int unsigned fill;
    in_stall_on  = 1'b1;
    out_stall_on = 1'b1;
    fill         = STACK_DEPTH - shadow_count;
    for (k = 0; k < fill; k++) begin
      send_request(REQ_PUSH, $urandom());
    end
    send_request(REQ_PUSH, $urandom());
    send_request(REQ_PUSH, $urandom());
    send_request(REQ_PEEK, 32'sd0);
    send_request(REQ_SWAP, 32'sd0);
    send_request(REQ_DUMP, 32'sd0);
    // Hold the sender until the full dump has drained.
    wait_for_quiet();
    out_stall_on = 1'b0;
    for (k = 0; k < STACK_DEPTH; k++) begin
      if ($urandom_range(0, 5) == 0) begin
        send_request($urandom_range(0, 1) ? REQ_PEEK : REQ_SWAP, 32'sd0);
      end
      send_request(REQ_POP, 32'sd0);
    end
    send_request(REQ_POP, 32'sd0);
    send_request(REQ_DUMP, 32'sd0);
    wait_for_quiet();
  endtask

  // Weighted random operations with random values; stalls switch on and off in stretches.
  task automatic test_random_ops(input int unsigned count);
    int unsigned        k;
    int unsigned        roll;
    logic [2:0]         code;
    logic signed [31:0] value;
    for (k = 0; k < count; k++) begin
      if (k % 40 == 0) begin
        in_stall_on  = ($urandom_range(0, 2) != 0);
        out_stall_on = ($urandom_range(0, 2) != 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        code = REQ_PUSH;
      end else if (roll < 60) begin
        code = REQ_POP;
      end else if (roll < 75) begin
        code = REQ_PEEK;
      end else if (roll < 90) begin
        code = REQ_SWAP;
      end else if (roll < 97) begin
        code = REQ_DUMP;
      end else begin
        code = 3'($urandom_range(5, 7));
      end
      // Keep the stack mostly in its middle range, with occasional runs to the top.
      if (code == REQ_PUSH && shadow_count > 24 && $urandom_range(0, 1) == 0) begin
        code = REQ_POP;
      end
      case ($urandom_range(0, 7))
        0:       value = 32'sh8000_0000;
        1:       value = 32'sh7FFF_FFFF;
        2:       value = 32'($signed($urandom_range(0, 15)) - 8);
        default: value = $urandom();
      endcase
      send_request(code, value);
    end
    wait_for_quiet();
  endtask

  // Broken sequences: error bursts on a shallow stack mixed with unused codes.
  task automatic test_error_noise(input int unsigned count);
    int unsigned k;
    in_stall_on  = 1'b1;
    out_stall_on = 1'b1;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(0, 5))
        0:       send_request(REQ_PUSH, $urandom());
        1:       send_request(REQ_SWAP, $urandom());
        2:       send_request(REQ_PEEK, $urandom());
        3:       send_request(3'($urandom_range(5, 7)), $urandom());
        default: send_request(REQ_POP, $urandom());
      endcase
    end
    wait_for_quiet();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_stack_errors();
    test_value_extremes();
    test_full_stack();
    test_random_ops(330);
    test_error_noise(30);
    if (results_due.size() != 0) begin
      note_failure($sformatf("%0d predicted results never arrived", results_due.size()));
    end
    $display("Run covered %0d accepted requests and %0d checked result beats.",
             requests_taken, beats_checked);
    $display("Error statuses seen: %0d; dumps of a full stack: %0d; mismatches: %0d.",
             error_beats, full_dumps, fail_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("Timeout: run did not finish in time.");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
